/* rtl/mlf_pkg.sv */
// Shared constants, codes and types for the median/low-pass line filter.
// No dependencies; design files use scoped names, the bench imports it.
package mlf_pkg;

    localparam int SMP_W    = 16;
    localparam int LEN_W    = 13;
    localparam int MAX_LINE = 4096;
    localparam int MIN_LINE = 4;
    localparam int POS_W    = $clog2(MAX_LINE);

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = LEN_W;
    localparam logic [CFG_AW-1:0] REG_MEDIAN  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_LOWPASS = 2'd1;
    localparam logic [CFG_AW-1:0] REG_LENGTH  = 2'd2;

    // position class of a median value within its line
    localparam int CLS_W = 3;
    localparam logic [CLS_W-1:0] CLS_MID    = 3'd0;
    localparam logic [CLS_W-1:0] CLS_FIRST  = 3'd1;
    localparam logic [CLS_W-1:0] CLS_SECOND = 3'd2;
    localparam logic [CLS_W-1:0] CLS_PEN    = 3'd3;
    localparam logic [CLS_W-1:0] CLS_LAST   = 3'd4;

    // divisor selection for the back end
    localparam int DIV_W = 2;
    localparam logic [DIV_W-1:0] DIV_ONE   = 2'd0;
    localparam logic [DIV_W-1:0] DIV_SIX   = 2'd1;
    localparam logic [DIV_W-1:0] DIV_EIGHT = 2'd2;
    localparam logic [DIV_W-1:0] DIV_NINE  = 2'd3;

    // weighted sum: at most 9 * 65535 + 4
    localparam int SUM_W     = 20;
    localparam int REC_W     = 22;
    localparam int REC_SHIFT = 24;
    localparam logic [REC_W-1:0] REC_SIX  = 22'd2796203;  // ceil(2^24 / 6)
    localparam logic [REC_W-1:0] REC_NINE = 22'd1864136;  // ceil(2^24 / 9)
    localparam int PROD_W    = SUM_W + REC_W;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [SMP_W-1:0] m;
        logic [CLS_W-1:0] cls;
    } t_ent;

    typedef struct packed {
        logic             median_en;
        logic             lowpass_en;
        logic [POS_W-1:0] last_pos;
    } t_cfg;

endpackage

/* rtl/mlf_in_if.sv */
// Sample channel: valid/ready handshake carrying one raw sample.
// Depends on mlf_pkg for the sample width.
interface mlf_in_if;
    logic                     valid;
    logic                     ready;
    logic [mlf_pkg::SMP_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/mlf_out_if.sv */
// Result channel: valid/ready handshake carrying one filtered value.
// Depends on mlf_pkg for the value width.
interface mlf_out_if;
    logic                     valid;
    logic                     ready;
    logic [mlf_pkg::SMP_W-1:0] value;
    logic                     end_of_line;

    modport source (output valid, output value, output end_of_line, input ready);
    modport sink   (input valid, input value, input end_of_line, output ready);
endinterface

/* rtl/mlf_front.sv */
// Front end: accepts samples, tracks line position, forms the median stream.
// Depends on mlf_pkg and mlf_in_if; writes at most one entry per cycle to mlf_queue.
module mlf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clr,
    input  mlf_pkg::t_cfg       i_cfg,
    mlf_in_if.sink              i_smp,
    input  logic                i_space,
    output logic                o_wr,
    output mlf_pkg::t_ent       o_wr_ent
);

    function automatic logic [mlf_pkg::SMP_W-1:0] med3(
        input logic [mlf_pkg::SMP_W-1:0] a,
        input logic [mlf_pkg::SMP_W-1:0] b,
        input logic [mlf_pkg::SMP_W-1:0] c
    );
        if (a < b) begin
            if (b < c) return b;
            return (a < c) ? c : a;
        end
        if (a < c) return a;
        return (b < c) ? c : b;
    endfunction

    logic [mlf_pkg::POS_W-1:0] r_pos, n_pos;
    logic                      r_tail_vld, n_tail_vld;
    logic [mlf_pkg::SMP_W-1:0] r_tail;
    logic [mlf_pkg::SMP_W-1:0] r_raw0;
    logic [mlf_pkg::SMP_W-1:0] r_raw1;

    logic                      need_wr;
    logic                      is_last;
    logic                      acc;
    logic [mlf_pkg::SMP_W-1:0] med_val;
    logic [mlf_pkg::CLS_W-1:0] med_cls;

    assign need_wr = (r_pos != '0);
    assign is_last = (r_pos == i_cfg.last_pos);

    // the first sample of a line writes nothing, which leaves room for a pending tail
    assign i_smp.ready = !need_wr || (i_space && !r_tail_vld);
    assign acc         = i_smp.valid && i_smp.ready;

    always_comb begin
        if (!i_cfg.median_en || (r_pos == mlf_pkg::POS_W'(1))) begin
            med_val = r_raw0;
        end else begin
            med_val = med3(r_raw1, r_raw0, i_smp.sample);
        end
        if (r_pos == mlf_pkg::POS_W'(1)) begin
            med_cls = mlf_pkg::CLS_FIRST;
        end else if (r_pos == mlf_pkg::POS_W'(2)) begin
            med_cls = mlf_pkg::CLS_SECOND;
        end else if (is_last) begin
            med_cls = mlf_pkg::CLS_PEN;
        end else begin
            med_cls = mlf_pkg::CLS_MID;
        end
    end

    always_comb begin
        o_wr         = 1'b0;
        o_wr_ent.m   = med_val;
        o_wr_ent.cls = med_cls;
        if (r_tail_vld) begin
            o_wr         = i_space;
            o_wr_ent.m   = r_tail;
            o_wr_ent.cls = mlf_pkg::CLS_LAST;
        end else if (acc && need_wr) begin
            o_wr = 1'b1;
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_tail_vld = r_tail_vld;
        if (r_tail_vld && i_space) begin
            n_tail_vld = 1'b0;
        end
        if (acc) begin
            if (is_last) begin
                n_pos      = '0;
                n_tail_vld = 1'b1;
            end else begin
                n_pos = r_pos + mlf_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_pos      <= '0;
            r_tail_vld <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_tail_vld <= n_tail_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (is_last) begin
                r_tail <= i_smp.sample;
            end else begin
                r_raw1 <= r_raw0;
                r_raw0 <= i_smp.sample;
            end
        end
    end

endmodule

/* rtl/mlf_queue.sv */
// Short register queue of median entries between the front and back ends.
// Depends on mlf_pkg for the entry type and depth.
module mlf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_wr,
    input  mlf_pkg::t_ent i_wr_ent,
    output logic          o_space,
    output logic          o_rd_valid,
    output mlf_pkg::t_ent o_rd_ent,
    input  logic          i_rd
);

    mlf_pkg::t_ent            r_mem [mlf_pkg::Q_DEPTH];
    logic [mlf_pkg::Q_AW-1:0] r_wr_ptr;
    logic [mlf_pkg::Q_AW-1:0] r_rd_ptr;
    logic [mlf_pkg::Q_CW-1:0] r_cnt, n_cnt;

    function automatic logic [mlf_pkg::Q_AW-1:0] ptr_inc(input logic [mlf_pkg::Q_AW-1:0] p);
        if (p == mlf_pkg::Q_AW'(mlf_pkg::Q_DEPTH - 1)) return '0;
        return p + mlf_pkg::Q_AW'(1);
    endfunction

    assign o_space    = (r_cnt != mlf_pkg::Q_CW'(mlf_pkg::Q_DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_ent   = r_mem[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + mlf_pkg::Q_CW'(1);
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - mlf_pkg::Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_rd) r_rd_ptr <= ptr_inc(r_rd_ptr);
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_ent;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (o_space || i_rd))
        else $error("queue written while full");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mlf_pkg::Q_CW'(mlf_pkg::Q_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

/* rtl/mlf_back.sv */
// Back end: five-value median window, weighted sum, reciprocal divide, output register.
// Depends on mlf_pkg and mlf_out_if; pops entries from mlf_queue.
module mlf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  mlf_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  mlf_pkg::t_ent i_q_ent,
    output logic          o_q_pop,
    mlf_out_if.source     o_res
);

    // window: index 0 newest; index 1 is the value whose result is formed at the shift
    logic [mlf_pkg::SMP_W-1:0] r_win [4];
    logic                      r_tvld [2];
    logic [mlf_pkg::CLS_W-1:0] r_tcls [2];
    logic [1:0]                r_flush, n_flush;

    // sum stage
    logic                      r_s_vld;
    logic [mlf_pkg::SUM_W-1:0] r_s_sum;
    logic [mlf_pkg::DIV_W-1:0] r_s_div;
    logic                      r_s_eol;

    // output register
    logic                      r_o_vld;
    logic [mlf_pkg::SMP_W-1:0] r_o_val;
    logic                      r_o_eol;

    logic                      shift_req, shift, emit_vld;
    logic                      o_adv, s_to_o, s_free;
    logic [mlf_pkg::SMP_W-1:0] new_val;
    logic [mlf_pkg::CLS_W-1:0] emit_cls;
    logic [mlf_pkg::SUM_W-1:0] t0, t1, t2, t3, t4;
    logic [mlf_pkg::SUM_W-1:0] sum;
    logic [mlf_pkg::DIV_W-1:0] div;
    logic [mlf_pkg::REC_W-1:0] rec;
    logic [mlf_pkg::PROD_W-1:0] prod;
    logic [mlf_pkg::SMP_W-1:0] quo;

    assign o_adv  = !r_o_vld || o_res.ready;
    assign s_to_o = r_s_vld && o_adv;
    assign s_free = !r_s_vld || s_to_o;

    // keep shifting after the end of a line until its last two results are formed
    assign shift_req = i_q_valid || (r_flush != 2'd0);
    assign emit_vld  = r_tvld[1];
    assign emit_cls  = r_tcls[1];
    assign shift     = shift_req && (!emit_vld || s_free);
    assign o_q_pop   = shift && i_q_valid;
    assign new_val   = i_q_valid ? i_q_ent.m : '0;

    // taps: the incoming value and the four stored values before the shift
    assign t0 = mlf_pkg::SUM_W'(new_val);
    assign t1 = mlf_pkg::SUM_W'(r_win[0]);
    assign t2 = mlf_pkg::SUM_W'(r_win[1]);
    assign t3 = mlf_pkg::SUM_W'(r_win[2]);
    assign t4 = mlf_pkg::SUM_W'(r_win[3]);

    always_comb begin
        if (!i_cfg.lowpass_en) begin
            sum = t2;
            div = mlf_pkg::DIV_ONE;
        end else begin
            case (emit_cls)
                mlf_pkg::CLS_FIRST: begin
                    sum = (t2 << 1) + t2 + (t1 << 1) + t0 + mlf_pkg::SUM_W'(3);
                    div = mlf_pkg::DIV_SIX;
                end
                mlf_pkg::CLS_SECOND: begin
                    sum = (t3 << 1) + (t2 << 1) + t2 + (t1 << 1) + t0 + mlf_pkg::SUM_W'(4);
                    div = mlf_pkg::DIV_EIGHT;
                end
                mlf_pkg::CLS_PEN: begin
                    sum = t4 + (t3 << 1) + (t2 << 1) + t2 + (t1 << 1) + mlf_pkg::SUM_W'(4);
                    div = mlf_pkg::DIV_EIGHT;
                end
                mlf_pkg::CLS_LAST: begin
                    sum = t4 + (t3 << 1) + (t2 << 1) + t2 + mlf_pkg::SUM_W'(3);
                    div = mlf_pkg::DIV_SIX;
                end
                default: begin
                    sum = t4 + (t3 << 1) + (t2 << 1) + t2 + (t1 << 1) + t0
                          + mlf_pkg::SUM_W'(4);
                    div = mlf_pkg::DIV_NINE;
                end
            endcase
        end
    end

    always_comb begin
        n_flush = r_flush;
        if (shift) begin
            if (i_q_valid && (i_q_ent.cls == mlf_pkg::CLS_LAST)) begin
                n_flush = 2'd2;
            end else if (r_flush != 2'd0) begin
                n_flush = r_flush - 2'd1;
            end
        end
    end

    // divide by six or nine through a reciprocal multiply, by eight through a shift
    assign rec  = (r_s_div == mlf_pkg::DIV_SIX) ? mlf_pkg::REC_SIX : mlf_pkg::REC_NINE;
    assign prod = mlf_pkg::PROD_W'(r_s_sum) * mlf_pkg::PROD_W'(rec);

    always_comb begin
        case (r_s_div)
            mlf_pkg::DIV_ONE:   quo = r_s_sum[mlf_pkg::SMP_W-1:0];
            mlf_pkg::DIV_EIGHT: quo = r_s_sum[3 +: mlf_pkg::SMP_W];
            default:            quo = prod[mlf_pkg::REC_SHIFT +: mlf_pkg::SMP_W];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_tvld[0] <= 1'b0;
            r_tvld[1] <= 1'b0;
            r_flush   <= 2'd0;
        end else begin
            if (shift) begin
                r_tvld[0] <= i_q_valid;
                r_tvld[1] <= r_tvld[0];
            end
            r_flush <= n_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (shift && emit_vld) begin
                r_s_vld <= 1'b1;
            end else if (s_to_o) begin
                r_s_vld <= 1'b0;
            end
            if (s_to_o) begin
                r_o_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_win[0]  <= new_val;
            r_win[1]  <= r_win[0];
            r_win[2]  <= r_win[1];
            r_win[3]  <= r_win[2];
            r_tcls[0] <= i_q_ent.cls;
            r_tcls[1] <= r_tcls[0];
        end
        if (shift && emit_vld) begin
            r_s_sum <= sum;
            r_s_div <= div;
            r_s_eol <= (emit_cls == mlf_pkg::CLS_LAST);
        end
        if (s_to_o) begin
            r_o_val <= quo;
            r_o_eol <= r_s_eol;
        end
    end

    assign o_res.valid       = r_o_vld;
    assign o_res.value       = r_o_val;
    assign o_res.end_of_line = r_o_eol;

`ifndef SYNTHESIS
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("queue popped while empty");

    a_flush_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush <= 2'd2)
        else $error("flush count beyond two");

    a_sum_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_clr)
        (r_s_vld && !s_to_o) |=> (r_s_vld && $stable(r_s_sum)))
        else $error("sum stage lost a result while stalled");
`endif

endmodule

/* rtl/median3_lowpass5_line_filter_top.sv */
// Line filter: optional 3-point median, then optional 1-2-3-2-1 smoothing per line.
// Throughput: one sample accepted and one result given per cycle while no side stalls.
// Result z becomes due once sample z+3 is taken, then passes the queue, the window,
// sum stage and output register; a line's last sample releases its final four results.
// Reset (synchronous, active low) clears positions, queue and valids, and restores
// the registers to median off, smoothing off, line length 4096; no clearing pass.
module median3_lowpass5_line_filter_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mlf_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [mlf_pkg::CFG_DW-1:0] i_cfg_wdata,
    mlf_in_if.sink                     i_smp,
    mlf_out_if.source                  o_res
);

    // Configuration registers. The line length is saturated to MIN_LINE..MAX_LINE
    // at write time and kept as the index of the last sample in a line.
    logic                      r_median_en;
    logic                      r_lowpass_en;
    logic [mlf_pkg::POS_W-1:0] r_last_pos, n_last_pos;
    logic [31:0]               w_len;
    mlf_pkg::t_cfg             cfg;

    // front to queue, queue to back
    logic          q_wr, q_space, q_valid, q_pop;
    mlf_pkg::t_ent q_wr_ent, q_rd_ent;

    assign w_len = 32'(i_cfg_wdata);

    always_comb begin
        if (w_len < 32'(mlf_pkg::MIN_LINE)) begin
            n_last_pos = mlf_pkg::POS_W'(mlf_pkg::MIN_LINE - 1);
        end else if (w_len > 32'(mlf_pkg::MAX_LINE)) begin
            n_last_pos = mlf_pkg::POS_W'(mlf_pkg::MAX_LINE - 1);
        end else begin
            n_last_pos = mlf_pkg::POS_W'(w_len - 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_median_en  <= 1'b0;
            r_lowpass_en <= 1'b0;
            r_last_pos   <= mlf_pkg::POS_W'(mlf_pkg::MAX_LINE - 1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mlf_pkg::REG_MEDIAN:  r_median_en  <= i_cfg_wdata[0];
                mlf_pkg::REG_LOWPASS: r_lowpass_en <= i_cfg_wdata[0];
                mlf_pkg::REG_LENGTH:  r_last_pos   <= n_last_pos;
                default: ;
            endcase
        end
    end

    assign cfg.median_en  = r_median_en;
    assign cfg.lowpass_en = r_lowpass_en;
    assign cfg.last_pos   = r_last_pos;

    // Any register write, to any index, abandons the line in progress: drop the
    // position, the pending tail and the window tags.
    mlf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (i_cfg_we),
        .i_cfg    (cfg),
        .i_smp    (i_smp),
        .i_space  (q_space),
        .o_wr     (q_wr),
        .o_wr_ent (q_wr_ent)
    );

    // The queue absorbs the start-of-line gap and the end-of-line flush so the
    // front and the back stall independently.
    mlf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (i_cfg_we),
        .i_wr       (q_wr),
        .i_wr_ent   (q_wr_ent),
        .o_space    (q_space),
        .o_rd_valid (q_valid),
        .o_rd_ent   (q_rd_ent),
        .i_rd       (q_pop)
    );

    // The back end forms at most one result per window shift: two median values behind
    // the newest, with zero fill after the end of a line when no input waits.
    mlf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (i_cfg_we),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_ent   (q_rd_ent),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

/* tb/sv/tb_median3_lowpass5_line_filter_top.sv */
// Self-checking testbench for median3_lowpass5_line_filter_top: directed table, then random
// phases, some with sender/receiver idling; results checked in order vs table or model.
// Depends on mlf_pkg, mlf_in_if, mlf_out_if and the filter top level.
`timescale 1ns / 100ps

module tb_median3_lowpass5_line_filter_top;
    import mlf_pkg::*;

    // write address past the register list: the block must still abort the line
    localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

    localparam int N_ROWS        = 36;
    localparam int SETTLE_CYCLES = 12;   // covers the end-of-line flush with margin
    localparam int HOLD_CYCLES   = 60;   // long receiver stall, fills the block
    localparam int MAX_PRINTS    = 50;

    typedef struct packed {
        logic [SMP_W-1:0] value;
        logic             eol;
    } t_result;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} t_row_kind;

    // One directed step: a register write or a sample. Sample rows marked typed carry
    // their results in vals (first result in the low 16 bits); eol goes on the last one.
    typedef struct packed {
        t_row_kind         kind;
        logic [CFG_AW-1:0] addr;
        logic [SMP_W-1:0]  word;
        logic              typed;
        logic [2:0]        n_typed;
        logic [63:0]       vals;
        logic              last_eol;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_wdata;

    mlf_in_if  smp_ch ();
    mlf_out_if res_ch ();

    median3_lowpass5_line_filter_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_smp       (smp_ch),
        .o_res       (res_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line filter model: register copies, raw and median windows, position
    // ------------------------------------------------------------------
    logic             med_en;
    logic             lp_en;
    logic [LEN_W-1:0] line_len;
    logic [SMP_W-1:0] raw_hist [3];   // [0] newest raw sample
    logic [SMP_W-1:0] med_hist [5];   // [0] newest median-stage value
    int unsigned      line_pos;

    t_result filtered_q [$];          // filtered values still owed by the block

    int          n_errors;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned hold_req;            // bumped by the stimulus to request a long stall
    logic [SMP_W-1:0] prev_sample;

    function automatic int unsigned active_len();
        if (line_len < LEN_W'(MIN_LINE)) return MIN_LINE;
        if (line_len > LEN_W'(MAX_LINE)) return MAX_LINE;
        return line_len;
    endfunction

    function automatic logic [SMP_W-1:0] mid_of3(logic [SMP_W-1:0] a, logic [SMP_W-1:0] b,
                                                  logic [SMP_W-1:0] c);
        if (a < b) begin
            if (b < c) return b;
            return (a < c) ? c : a;
        end
        if (a < c) return a;
        return (b < c) ? c : b;
    endfunction

    // m[z+d] when the newest median value is m[z+off]; missing taps read as zero
    function automatic int unsigned med_tap(int off, int d);
        int i;
        i = off - d;
        if (i < 0 || i > 4) return 0;
        return med_hist[i];
    endfunction

    function automatic t_result smooth_at(int unsigned z, int off, int unsigned len);
        int unsigned a, b, c, d, e, v;
        t_result     r;
        a = med_tap(off, -2);
        b = med_tap(off, -1);
        c = med_tap(off, 0);
        d = med_tap(off, 1);
        e = med_tap(off, 2);
        if (!lp_en)               v = c;
        else if (z == 0)          v = (3 * c + 2 * d + e + 3) / 6;
        else if (z == 1)          v = (2 * b + 3 * c + 2 * d + e + 4) / 8;
        else if (z == len - 2)    v = (a + 2 * b + 3 * c + 2 * d + 4) / 8;
        else if (z == len - 1)    v = (a + 2 * b + 3 * c + 3) / 6;
        else                      v = (a + 2 * b + 3 * c + 2 * d + e + 4) / 9;
        r.value = v[SMP_W-1:0];
        r.eol   = (z == len - 1);
        return r;
    endfunction

    function automatic void shift_median(logic [SMP_W-1:0] v);
        for (int i = 4; i > 0; i--) med_hist[i] = med_hist[i-1];
        med_hist[0] = v;
    endfunction

    function automatic void clear_line();
        foreach (raw_hist[i]) raw_hist[i] = '0;
        foreach (med_hist[i]) med_hist[i] = '0;
        line_pos = 0;
    endfunction

    // Append one result to the list the block still owes.
    function automatic void owe_result(t_result r);
        filtered_q.insert(filtered_q.size(), r);
    endfunction

    function automatic void apply_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
        case (addr)
            REG_MEDIAN:  med_en   = data[0];
            REG_LOWPASS: lp_en    = data[0];
            REG_LENGTH:  line_len = data;
            default: ;
        endcase
        // any write aborts the line in progress
        clear_line();
    endfunction

    // Advance the model by one accepted sample; queue its results when keep is set.
    function automatic void filter_step(logic [SMP_W-1:0] s, bit keep);
        int unsigned      len, p;
        logic [SMP_W-1:0] m;
        len = active_len();
        p   = line_pos;
        if (p >= len) p = len - 1;
        if (p >= 1) begin
            m = (!med_en || p == 1) ? raw_hist[0] : mid_of3(raw_hist[1], raw_hist[0], s);
            shift_median(m);
        end
        if (p >= 3 && keep) owe_result(smooth_at(p - 3, 2, len));
        if (p == len - 1) begin
            // last sample of the line: flush the remaining results
            shift_median(s);
            if (keep) begin
                owe_result(smooth_at(len - 3, 2, len));
                owe_result(smooth_at(len - 2, 1, len));
                owe_result(smooth_at(len - 1, 0, len));
            end
            clear_line();
        end else begin
            raw_hist[2] = raw_hist[1];
            raw_hist[1] = raw_hist[0];
            raw_hist[0] = s;
            line_pos    = p + 1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    t_row dir_rows [N_ROWS] = '{
        // defaults after reset: both filters off, length 4096, results lag three samples
        '{ROW_SAMPLE, REG_MEDIAN,  16'hFFFF, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'h0000, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'h8000, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'h7FFF, 1'b1, 3'd1, 64'h0000_0000_0000_FFFF, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'h5555, 1'b1, 3'd1, 64'h0000_0000_0000_0000, 1'b0},
        // length zero saturates to four; pass-through, the last sample flushes four
        '{ROW_WRITE,  REG_LENGTH,  16'h0000, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'hFFFF, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'h0000, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'hAAAA, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'h5555, 1'b1, 3'd4, 64'h5555_AAAA_0000_FFFF, 1'b1},
        // median only, line of five: spikes removed, end samples kept raw
        '{ROW_WRITE,  REG_MEDIAN,  16'h0001, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_WRITE,  REG_LENGTH,  16'h0005, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'h000A, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'hFFFF, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'h0000, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'hFFFF, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'h0014, 1'b0, 3'd0, 64'h0, 1'b0},
        // both filters on, full-scale line: every kernel must return full scale
        '{ROW_WRITE,  REG_LOWPASS, 16'h0001, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'hFFFF, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'hFFFF, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'hFFFF, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'hFFFF, 1'b1, 3'd1, 64'h0000_0000_0000_FFFF, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'hFFFF, 1'b1, 3'd4, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
        // smoothing only, length three saturates to four: both edge kernels, no middle
        '{ROW_WRITE,  REG_MEDIAN,  16'h0000, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_WRITE,  REG_LENGTH,  16'h0003, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'h0000, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'hFFFF, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'h0000, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'hFFFF, 1'b0, 3'd0, 64'h0, 1'b0},
        // write past the list, then the largest length code (saturates to 4096)
        '{ROW_WRITE,  REG_UNUSED,  16'h1FFF, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_WRITE,  REG_LENGTH,  16'h1FFF, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_WRITE,  REG_MEDIAN,  16'h1FFF, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'h1234, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'hEDCB, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'h0001, 1'b0, 3'd0, 64'h0, 1'b0},
        '{ROW_SAMPLE, REG_MEDIAN,  16'hFFFE, 1'b0, 3'd0, 64'h0, 1'b0}
    };

    // ------------------------------------------------------------------
    // Stimulus helpers (all called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------

    // Offer one sample; idle first at the sender's rate. Valid stays high afterward
    // so the next item can follow back to back.
    task automatic put_sample(input logic [SMP_W-1:0] s, input bit keep);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            smp_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        smp_ch.valid  = 1'b1;
        smp_ch.sample = s;
        do @(posedge i_clk); while (!smp_ch.ready);
        filter_step(s, keep);
        @(negedge i_clk);
    endtask

    // Drop valid, let every owed result drain, then let the pipeline settle.
    task automatic wait_quiet();
        smp_ch.valid = 1'b0;
        while (filtered_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        apply_reg(addr, data);
    endtask

    // Mix of extremes, full random and near-neighbor values (keeps the median busy).
    function automatic logic [SMP_W-1:0] pick_sample();
        logic [SMP_W-1:0] s;
        case ($urandom_range(0, 7))
            0:       s = '0;
            1:       s = '1;
            2, 3, 4: s = SMP_W'($urandom);
            default: s = prev_sample + SMP_W'($urandom_range(0, 64)) - SMP_W'(32);
        endcase
        prev_sample = s;
        return s;
    endfunction

    // One random phase: fresh settings written while idle, then a burst of samples.
    task automatic run_phase(input int n_items, input bit with_hold);
        logic [CFG_DW-1:0] len_code;
        wait_quiet();
        write_reg(REG_MEDIAN, CFG_DW'($urandom_range(0, 8191)));
        write_reg(REG_LOWPASS, CFG_DW'($urandom_range(0, 8191)));
        case ($urandom_range(0, 9))
            0:       len_code = CFG_DW'($urandom_range(0, 3));        // saturates up
            1:       len_code = CFG_DW'($urandom_range(4096, 8191));  // longest line
            2:       len_code = CFG_DW'($urandom_range(0, 8191));
            3:       len_code = CFG_DW'(MIN_LINE);
            default: len_code = CFG_DW'($urandom_range(5, 16));
        endcase
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DW'($urandom_range(0, 8191)));
        write_reg(REG_LENGTH, len_code);
        if (with_hold) hold_req++;
        for (int i = 0; i < n_items; i++) put_sample(pick_sample(), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern and in-order checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (n_errors < MAX_PRINTS)
            $display("ERROR %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Drive ready at the falling edge; a hold request stalls it for HOLD_CYCLES.
    initial begin
        int unsigned hold_left;
        int unsigned hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_ch.ready = 1'b0;
                hold_left--;
            end else begin
                res_ch.ready = !(snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (filtered_q.size() == 0) begin
                report_mismatch("result with nothing outstanding", res_ch.value, 0);
            end else begin
                want = filtered_q.pop_front();
                if (res_ch.value !== want.value)
                    report_mismatch("value", res_ch.value, want.value);
                if (res_ch.end_of_line !== want.eol)
                    report_mismatch("end_of_line", res_ch.end_of_line, want.eol);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_MEDIAN;
        i_cfg_wdata   = '0;
        smp_ch.valid  = 1'b0;
        smp_ch.sample = '0;
        n_errors      = 0;
        hold_req      = 0;
        prev_sample   = '0;
        // first the sender idles rarely and the receiver often
        src_idle_pct  = 6;
        snk_idle_pct  = 70;
        med_en        = 1'b0;
        lp_en         = 1'b0;
        line_len      = LEN_W'(MAX_LINE);
        clear_line();

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed table: typed rows queue their listed results, others use the model
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_WRITE) begin
                wait_quiet();
                write_reg(dir_rows[r].addr, dir_rows[r].word[CFG_DW-1:0]);
            end else begin
                put_sample(dir_rows[r].word, !dir_rows[r].typed);
                for (int j = 0; j < dir_rows[r].n_typed; j++)
                    owe_result('{dir_rows[r].vals[16*j +: 16],
                        (j == dir_rows[r].n_typed - 1) ? dir_rows[r].last_eol : 1'b0});
            end
        end

        // random phases: sender rare / receiver busy, then swapped, then no idling
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0:       begin src_idle_pct = 6;  snk_idle_pct = 70; end
                1:       begin src_idle_pct = 70; snk_idle_pct = 6;  end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase
            for (int k = 0; k < 4; k++)
                run_phase($urandom_range(24, 34), mode == 2 && k == 0);
        end

        wait_quiet();
        if (n_errors == 0) begin
            $display("median3_lowpass5_line_filter_top regression: pass");
        end else begin
            $display("median3_lowpass5_line_filter_top regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("median3_lowpass5_line_filter_top regression: fail");
        $finish;
    end

endmodule
